// File: rtl/uadw_pkg.sv
// ----------------------------------------------------------------------------
// uadw_pkg
// Shared types, byte codes and helpers for the terminal display width block.
// ----------------------------------------------------------------------------
package uadw_pkg;

  localparam int SUM_BITS_DEF = 16;
  localparam int TOTAL_BITS   = 16;

  localparam logic [7:0] BYTE_NUL   = 8'h00;
  localparam logic [7:0] BYTE_ESC   = 8'h1B;
  localparam logic [7:0] BYTE_CSI   = 8'h5B;  // '['
  localparam logic [7:0] BYTE_SGR_M = 8'h6D;  // 'm'
  localparam logic [7:0] BYTE_E2    = 8'hE2;

  // Scan mode of the escape sequence tracker. Code 3 is never produced.
  typedef enum logic [1:0] {
    MODE_TEXT = 2'd0,
    MODE_ESC  = 2'd1,
    MODE_CSI  = 2'd2
  } scan_mode_t;

  // Effect of one byte seen in normal text mode.
  typedef struct packed {
    logic       esc;      // byte opens an escape
    logic       e2_lead;  // byte is the E2 lead, width decided by next byte
    logic [1:0] add;      // columns to add now
    logic [1:0] skip;     // continuation bytes to skip afterwards
  } byte_class_t;

  // Second bytes after an E2 lead that give a one-column glyph.
  function automatic logic narrow_e2_second(input logic [7:0] c);
    logic hit;
    case (c)
      8'h80, 8'h86, 8'h94, 8'h95, 8'h96, 8'h98, 8'h9A, 8'h9B: hit = 1'b1;
      default:                                                hit = 1'b0;
    endcase
    return hit;
  endfunction

endpackage

// File: rtl/utf8_ansi_display_width.sv
// ----------------------------------------------------------------------------
// utf8_ansi_display_width
// Sums the terminal display width of a NUL-terminated UTF-8 byte string.
// ----------------------------------------------------------------------------
// Usage:
//   Bytes enter on the in_ channel (valid/ready), one per transaction. Every
//   byte updates the scan state and the running column sum in the cycle it
//   is accepted. A NUL byte ends the string: one transaction carrying
//   out_total_width and out_width_saturated appears on the out_ channel in
//   the next cycle, and the sum and scan state are cleared.
//   Throughput is one byte per cycle while in_ready is high; the result
//   is held in the single result register. All per-byte work is one byte
//   decode and one saturating add.
//   ANSI escapes (ESC '[' ... 'm') add nothing; UTF-8 leads choose width and
//   continuation skip count.
//   While a result waits and out_ready is low, in_ready stays low so the
//   held result is not overwritten; it rises again in the cycle the result
//   is taken. Synchronous reset (rst_n low) clears the sum, the scan state
//   and the result valid flag.
// ----------------------------------------------------------------------------
module utf8_ansi_display_width #(
  parameter int SUM_BITS = uadw_pkg::SUM_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    in_text_byte,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [uadw_pkg::TOTAL_BITS-1:0] out_total_width,
  output logic                          out_width_saturated
);
  import uadw_pkg::*;

  scan_mode_t          mode_r, mode_nxt;
  logic [1:0]          skip_r, skip_nxt;
  logic                e2_pending_r, e2_pending_nxt;
  logic [SUM_BITS-1:0] sum_r, sum_nxt;
  logic                ovf_r, ovf_nxt;

  logic                  out_valid_r;
  logic [TOTAL_BITS-1:0] total_r;
  logic                  sat_r;

  byte_class_t         cls;
  logic [1:0]          add;
  logic [SUM_BITS:0]   sum_ext;
  logic [SUM_BITS-1:0] sum_sat;
  logic                ovf_now;
  logic [31:0]         sum_wide;
  logic                accept;
  logic                is_nul;

  uadw_classify u_classify (
    .text_byte (in_text_byte),
    .cls       (cls)
  );

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign is_nul   = (in_text_byte == BYTE_NUL);

  // Column count contributed by the current byte.
  always_comb begin
    add = 2'd0;
    if (is_nul) begin
      add = e2_pending_r ? 2'd2 : 2'd0;
    end else if (e2_pending_r) begin
      add = narrow_e2_second(in_text_byte) ? 2'd1 : 2'd2;
    end else if (skip_r != 2'd0) begin
      add = 2'd0;
    end else if (mode_r == MODE_ESC && in_text_byte == BYTE_CSI) begin
      add = 2'd0;
    end else if (mode_r == MODE_CSI) begin
      add = 2'd0;
    end else begin
      add = cls.add;
    end
  end

  assign sum_ext  = {1'b0, sum_r} + (SUM_BITS + 1)'(add);
  assign ovf_now  = sum_ext[SUM_BITS];
  assign sum_sat  = ovf_now ? {SUM_BITS{1'b1}} : sum_ext[SUM_BITS-1:0];
  assign sum_wide = 32'(sum_sat);

  always_comb begin
    mode_nxt       = mode_r;
    skip_nxt       = skip_r;
    e2_pending_nxt = e2_pending_r;
    sum_nxt        = sum_sat;
    ovf_nxt        = ovf_r | ovf_now;
    if (is_nul) begin
      mode_nxt       = MODE_TEXT;
      skip_nxt       = 2'd0;
      e2_pending_nxt = 1'b0;
      sum_nxt        = '0;
      ovf_nxt        = 1'b0;
    end else if (e2_pending_r) begin
      e2_pending_nxt = 1'b0;
    end else if (skip_r != 2'd0) begin
      skip_nxt = skip_r - 2'd1;
    end else if (mode_r == MODE_ESC && in_text_byte == BYTE_CSI) begin
      mode_nxt = MODE_CSI;
    end else if (mode_r == MODE_CSI) begin
      if (in_text_byte == BYTE_SGR_M) begin
        mode_nxt = MODE_TEXT;
      end
    end else begin
      // Normal text, which also covers the byte after a lone ESC.
      mode_nxt       = cls.esc ? MODE_ESC : MODE_TEXT;
      skip_nxt       = cls.skip;
      e2_pending_nxt = cls.e2_lead;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MODE_TEXT;
      skip_r       <= 2'd0;
      e2_pending_r <= 1'b0;
      sum_r        <= '0;
      ovf_r        <= 1'b0;
    end else if (accept) begin
      mode_r       <= mode_nxt;
      skip_r       <= skip_nxt;
      e2_pending_r <= e2_pending_nxt;
      sum_r        <= sum_nxt;
      ovf_r        <= ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept && is_nul) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && is_nul) begin
      total_r <= sum_wide[TOTAL_BITS-1:0];
      sat_r   <= ovf_r | ovf_now;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_total_width     = total_r;
  assign out_width_saturated = sat_r;

  a_nul_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept && is_nul |=> out_valid_r)
    else $error("accepted NUL did not produce a result");

  a_nul_clears_state: assert property (@(posedge clk) disable iff (!rst_n)
    accept && is_nul |=> sum_r == '0 && !ovf_r && skip_r == 2'd0 &&
                         !e2_pending_r && mode_r == MODE_TEXT)
    else $error("scan state not cleared after end of string");

  a_e2_skip: assert property (@(posedge clk) disable iff (!rst_n)
    e2_pending_r |-> skip_r == 2'd1)
    else $error("E2 pending without its trailing skip");

  a_ovf_pinned: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |-> sum_r == {SUM_BITS{1'b1}})
    else $error("overflow flagged but sum not saturated");

endmodule

// File: rtl/uadw_classify.sv
// ----------------------------------------------------------------------------
// uadw_classify
// Decodes one text byte: escape start, UTF-8 lead class, width and skip count.
// ----------------------------------------------------------------------------
module uadw_classify (
  input  logic [7:0]           text_byte,
  output uadw_pkg::byte_class_t cls
);
  import uadw_pkg::*;

  always_comb begin
    cls = '0;
    if (text_byte == BYTE_ESC) begin
      cls.esc = 1'b1;
    end else if (text_byte[7] == 1'b0) begin
      cls.add = 2'd1;
    end else if (text_byte[7:5] == 3'b110) begin
      cls.add  = 2'd2;
      cls.skip = 2'd1;
    end else if (text_byte[7:4] == 4'b1110) begin
      if (text_byte == BYTE_E2) begin
        // Width waits for the second byte; only the third byte is skipped.
        cls.e2_lead = 1'b1;
        cls.skip    = 2'd1;
      end else begin
        cls.add  = 2'd2;
        cls.skip = 2'd2;
      end
    end else if (text_byte[7:3] == 5'b11110) begin
      cls.add  = 2'd2;
      cls.skip = 2'd3;
    end else begin
      // Stray continuation bytes and F8..FF take one column.
      cls.add = 2'd1;
    end
  end

endmodule

// File: tb/tb_utf8_ansi_display_width.sv
// ----------------------------------------------------------------------------
// tb_utf8_ansi_display_width
// Self-checking testbench for the terminal display width block. A short table
// of strings covers escapes, UTF-8 leads, the E2 special glyphs and a NUL that
// cuts a sequence short. A random part then mixes well-formed text with
// noise. The column count of every string is predicted, or taken from the
// table row that gives it, and compared with each result transaction.
// ----------------------------------------------------------------------------
module tb_utf8_ansi_display_width;
  timeunit 1ns;
  timeprecision 1ps;

  import uadw_pkg::*;

  localparam int SUM_BITS       = SUM_BITS_DEF;
  localparam int STALL_LIMIT    = 1000;
  localparam int RANDOM_BYTES   = 520;
  localparam int LONG_HOLD      = 150;
  localparam int HOLD_AT_RESULT = 10;
  localparam int MAX_REPORTS    = 10;
  localparam logic [SUM_BITS-1:0] SUM_MAX = '1;

  typedef struct packed {
    logic [TOTAL_BITS-1:0] total;
    logic                  sat;
  } width_result_t;

  typedef struct packed {
    logic [7:0]    text;
    logic          typed;  // the result below is the expected one
    width_result_t want;
  } text_row_t;

  localparam logic [7:0] NARROW_SECOND [8] = '{
    8'h80, 8'h86, 8'h94, 8'h95, 8'h96, 8'h98, 8'h9A, 8'h9B
  };

  localparam text_row_t DIRECTED_TEXT [28] = '{
    // Empty string right after reset.
    {BYTE_NUL, 1'b1, 16'd0, 1'b0},
    // Complete escape, then ESC followed by a byte that is plain text.
    {BYTE_ESC, 1'b0, 16'd0, 1'b0},
    {BYTE_CSI, 1'b0, 16'd0, 1'b0},
    {BYTE_SGR_M, 1'b0, 16'd0, 1'b0},
    {BYTE_ESC, 1'b0, 16'd0, 1'b0},
    {8'hFF, 1'b0, 16'd0, 1'b0},
    {BYTE_NUL, 1'b1, 16'd1, 1'b0},
    // Two-, four- and three-byte glyphs, narrow and wide E2, then a NUL
    // that cuts a four-byte skip short with an ESC being skipped.
    {8'hC3, 1'b0, 16'd0, 1'b0},
    {8'hA9, 1'b0, 16'd0, 1'b0},
    {8'hF0, 1'b0, 16'd0, 1'b0},
    {8'h9F, 1'b0, 16'd0, 1'b0},
    {8'h98, 1'b0, 16'd0, 1'b0},
    {8'h80, 1'b0, 16'd0, 1'b0},
    {BYTE_E2, 1'b0, 16'd0, 1'b0},
    {8'h94, 1'b0, 16'd0, 1'b0},
    {8'h80, 1'b0, 16'd0, 1'b0},
    {BYTE_E2, 1'b0, 16'd0, 1'b0},
    {8'h41, 1'b0, 16'd0, 1'b0},
    {8'h42, 1'b0, 16'd0, 1'b0},
    {8'hF0, 1'b0, 16'd0, 1'b0},
    {BYTE_ESC, 1'b0, 16'd0, 1'b0},
    {BYTE_NUL, 1'b0, 16'd0, 1'b0},
    // ESC ESC opens a fresh escape; the string ends inside it.
    {BYTE_ESC, 1'b0, 16'd0, 1'b0},
    {BYTE_ESC, 1'b0, 16'd0, 1'b0},
    {BYTE_CSI, 1'b0, 16'd0, 1'b0},
    {BYTE_NUL, 1'b1, 16'd0, 1'b0},
    // String ends while an E2 lead waits for its second byte.
    {BYTE_E2, 1'b0, 16'd0, 1'b0},
    {BYTE_NUL, 1'b1, 16'd2, 1'b0}
  };

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic [7:0]            in_text_byte;
  logic                  out_valid;
  logic                  out_ready;
  logic [TOTAL_BITS-1:0] out_total_width;
  logic                  out_width_saturated;

  width_result_t expected_widths [$];
  logic [7:0]    string_bytes [$];
  logic          calm;
  int            fail_count = 0;
  int            quiet_cycles = 0;

  // Predicted scan state of the block.
  scan_mode_t          col_mode;
  logic [1:0]          col_skip;
  logic                col_e2;
  logic [SUM_BITS-1:0] col_sum;
  logic                col_ovf;

  utf8_ansi_display_width #(
    .SUM_BITS(SUM_BITS)
  ) DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_text_byte        (in_text_byte),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_total_width     (out_total_width),
    .out_width_saturated (out_width_saturated)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void clear_scan();
    col_mode = MODE_TEXT;
    col_skip = '0;
    col_e2   = 1'b0;
    col_sum  = '0;
    col_ovf  = 1'b0;
  endfunction

  function automatic void add_columns(int n);
    logic [SUM_BITS:0] t;
    t = {1'b0, col_sum} + (SUM_BITS + 1)'(n);
    if (t > {1'b0, SUM_MAX}) begin
      col_sum = SUM_MAX;
      col_ovf = 1'b1;
    end else begin
      col_sum = t[SUM_BITS-1:0];
    end
  endfunction

  function automatic logic is_narrow_second(logic [7:0] c);
    logic hit;
    hit = 1'b0;
    foreach (NARROW_SECOND[i])
      if (NARROW_SECOND[i] == c) hit = 1'b1;
    return hit;
  endfunction

  function automatic void take_text_byte(logic [7:0] c);
    if (c == BYTE_ESC) begin
      col_mode = MODE_ESC;
      return;
    end
    col_mode = MODE_TEXT;
    if (c < 8'h80) begin
      add_columns(1);
    end else if ((c & 8'hE0) == 8'hC0) begin
      add_columns(2);
      col_skip = 2'd1;
    end else if ((c & 8'hF0) == 8'hE0) begin
      if (c == BYTE_E2) begin
        col_e2   = 1'b1;
        col_skip = 2'd1;
      end else begin
        add_columns(2);
        col_skip = 2'd2;
      end
    end else if ((c & 8'hF8) == 8'hF0) begin
      add_columns(2);
      col_skip = 2'd3;
    end else begin
      add_columns(1);
    end
  endfunction

  // Returns 1 when the byte ends the string, with the column count in r.
  function automatic logic predict_columns(input logic [7:0] c, output width_result_t r);
    r = '0;
    if (c == BYTE_NUL) begin
      if (col_e2) add_columns(2);
      r.total = col_sum[TOTAL_BITS-1:0];
      r.sat   = col_ovf;
      clear_scan();
      return 1'b1;
    end
    if (col_e2) begin
      col_e2 = 1'b0;
      add_columns(is_narrow_second(c) ? 1 : 2);
      return 1'b0;
    end
    if (col_skip != 2'd0) begin
      col_skip = col_skip - 2'd1;
      return 1'b0;
    end
    case (col_mode)
      MODE_ESC: begin
        if (c == BYTE_CSI) col_mode = MODE_CSI;
        else take_text_byte(c);
      end
      MODE_CSI: begin
        if (c == BYTE_SGR_M) col_mode = MODE_TEXT;
      end
      default: begin
        take_text_byte(c);
      end
    endcase
    return 1'b0;
  endfunction

  // Called right after a rising edge; returns right after the accepting edge.
  task automatic send_text_byte(input logic [7:0] c, input logic typed,
                                input width_result_t want);
    int            gap;
    logic          taken;
    width_result_t got;
    gap = calm ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_text_byte <= c;
    do begin
      @(negedge clk);
      taken = in_ready;
      @(posedge clk);
    end while (!taken);
    if (predict_columns(c, got))
      expected_widths.push_back(typed ? want : got);
  endtask

  function automatic logic [7:0] cont_byte();
    return 8'h80 | 8'($urandom_range(0, 63));
  endfunction

  // Mostly well-formed glyphs and escapes, with noise and truncated leads.
  task automatic build_random_string();
    int n;
    int d;
    string_bytes.delete();
    n = $urandom_range(0, 8);
    repeat (n) begin
      case ($urandom_range(0, 15))
        0, 1, 2, 3, 4: string_bytes.push_back(8'($urandom_range(8'h20, 8'h7E)));
        5: begin
          string_bytes.push_back(8'hC0 | 8'($urandom_range(0, 31)));
          string_bytes.push_back(cont_byte());
        end
        6: begin
          string_bytes.push_back(8'hE0 | 8'($urandom_range(0, 15)));
          string_bytes.push_back(cont_byte());
          string_bytes.push_back(cont_byte());
        end
        7: begin
          string_bytes.push_back(BYTE_E2);
          string_bytes.push_back(NARROW_SECOND[$urandom_range(0, 7)]);
          string_bytes.push_back(cont_byte());
        end
        8: begin
          string_bytes.push_back(8'hF0 | 8'($urandom_range(0, 7)));
          repeat (3) string_bytes.push_back(cont_byte());
        end
        9, 10: begin
          string_bytes.push_back(BYTE_ESC);
          string_bytes.push_back(BYTE_CSI);
          repeat ($urandom_range(0, 3)) begin
            d = $urandom_range(0, 10);
            string_bytes.push_back(d == 10 ? 8'h3B : 8'h30 + 8'(d));
          end
          string_bytes.push_back(BYTE_SGR_M);
        end
        11: begin
          string_bytes.push_back(BYTE_ESC);
          string_bytes.push_back(8'($urandom_range(1, 255)));
        end
        12, 13: string_bytes.push_back(8'($urandom_range(1, 255)));
        14: string_bytes.push_back(8'($urandom_range(8'hC0, 8'hF7)));
        default: string_bytes.push_back(8'($urandom_range(8'h80, 8'hFF)));
      endcase
    end
    string_bytes.push_back(BYTE_NUL);
  endtask

  // Result side: random stalls, one long hold-off to back the block up.
  initial begin
    int            stall;
    int            results_seen;
    logic          seen;
    width_result_t got;
    width_result_t want;
    out_ready    = 1'b0;
    results_seen = 0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 17);
      if (results_seen == HOLD_AT_RESULT) stall = LONG_HOLD;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do begin
        @(negedge clk);
        seen      = out_valid;
        got.total = out_total_width;
        got.sat   = out_width_saturated;
        @(posedge clk);
      end while (!seen);
      results_seen++;
      if (expected_widths.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("unexpected result: total_width %0d saturated %0b",
                   got.total, got.sat);
      end else begin
        want = expected_widths.pop_front();
        if (got.total !== want.total || got.sat !== want.sat) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("mismatch: total_width exp %0d got %0d, saturated exp %0b got %0b",
                     want.total, got.total, want.sat, got.sat);
        end
      end
    end
  end

  // Ends the run when no transaction happens on either channel for too long.
  always @(negedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb_utf8_ansi_display_width: done, errors");
      $finish;
    end
  end

  initial begin
    width_result_t none;
    int            random_sent;
    none         = '0;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_text_byte = '0;
    calm         = 1'b0;
    clear_scan();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIRECTED_TEXT[i])
      send_text_byte(DIRECTED_TEXT[i].text, DIRECTED_TEXT[i].typed, DIRECTED_TEXT[i].want);

    random_sent = 0;
    while (random_sent < RANDOM_BYTES) begin
      calm = ($urandom_range(0, 3) == 0);
      build_random_string();
      foreach (string_bytes[j]) send_text_byte(string_bytes[j], 1'b0, none);
      random_sent += string_bytes.size();
    end
    in_valid <= 1'b0;

    while (expected_widths.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0 && expected_widths.size() == 0)
      $display("tb_utf8_ansi_display_width: done, clean");
    else
      $display("tb_utf8_ansi_display_width: done, errors");
    $finish;
  end

endmodule

// File: utf8_ansi_display_width.f
rtl/uadw_pkg.sv
rtl/uadw_classify.sv
rtl/utf8_ansi_display_width.sv
tb/tb_utf8_ansi_display_width.sv
